@@ hw/rtl/odrc_pkg.sv @@
// ----------------------------------------------------------------------------
// odrc_pkg: shared constants and types for the overlap record converter
// Field widths, code names and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package odrc_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int ID_BITS_DEF    = 32;

    localparam int DIFF_BITS   = 20;
    localparam int HANG_BITS   = 21;
    localparam int ERATE_BITS  = 16;
    localparam int SCALE_BITS  = 14;
    localparam int NUM_BITS    = DIFF_BITS + SCALE_BITS;
    localparam int STEP_BITS   = $clog2(ERATE_BITS);

    localparam logic [SCALE_BITS-1:0] ERATE_SCALE = SCALE_BITS'(10000);
    localparam logic [ERATE_BITS-1:0] ERATE_MAX   = '1;

    // Coordinate slots of one record
    localparam int N_CRD = 6;
    localparam int C_SA  = 0;
    localparam int C_EA  = 1;
    localparam int C_LA  = 2;
    localparam int C_SB  = 3;
    localparam int C_EB  = 4;
    localparam int C_LB  = 5;

    localparam logic FUNC_REC   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic MODE_TRIM = 1'b0;
    localparam logic MODE_HANG = 1'b1;

    typedef struct packed {
        logic take;       // input side open
        logic store;      // copy captured record into cache
        logic clear;      // drop cache contents
        logic load_work;  // copy cache into the conversion registers
        logic mult;       // form diffs * scale and the A span
        logic check;      // saturation test, divider setup
        logic step;       // one divider step
        logic write;      // load the output register
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_flush;
        logic keep;
        logic cache_valid;
        logic same_key;
        logic better;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/odrc_in_if.sv @@
// ----------------------------------------------------------------------------
// odrc_in_if: alignment record input channel
// Valid/ready channel carrying one alignment record or a flush per item.
// ----------------------------------------------------------------------------
interface odrc_in_if
    import odrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [ID_BITS-1:0]    id_a;
    logic [ID_BITS-1:0]    id_b;
    logic                  fwd;
    logic [COORD_BITS-1:0] start_a;
    logic [COORD_BITS-1:0] end_a;
    logic [COORD_BITS-1:0] len_a;
    logic [COORD_BITS-1:0] start_b;
    logic [COORD_BITS-1:0] end_b;
    logic [COORD_BITS-1:0] len_b;
    logic [DIFF_BITS-1:0]  diffs;

    modport source (
        output valid, func, id_a, id_b, fwd, start_a, end_a, len_a,
               start_b, end_b, len_b, diffs,
        input  ready
    );

    modport sink (
        input  valid, func, id_a, id_b, fwd, start_a, end_a, len_a,
               start_b, end_b, len_b, diffs,
        output ready
    );
endinterface

@@ hw/rtl/odrc_out_if.sv @@
// ----------------------------------------------------------------------------
// odrc_out_if: converted record output channel
// Valid/ready channel carrying one trim or hang record per item.
// ----------------------------------------------------------------------------
interface odrc_out_if
    import odrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
();
    logic                        valid;
    logic                        ready;
    logic                        rec_kind;
    logic [ID_BITS-1:0]          out_id_a;
    logic [ID_BITS-1:0]          out_id_b;
    logic                        out_fwd;
    logic [COORD_BITS-1:0]       a_beg;
    logic [COORD_BITS-1:0]       a_fin;
    logic [COORD_BITS-1:0]       b_beg;
    logic [COORD_BITS-1:0]       b_fin;
    logic signed [HANG_BITS-1:0] hang_a;
    logic signed [HANG_BITS-1:0] hang_b;
    logic [ERATE_BITS-1:0]       err_rate;

    modport source (
        output valid, rec_kind, out_id_a, out_id_b, out_fwd, a_beg, a_fin,
               b_beg, b_fin, hang_a, hang_b, err_rate,
        input  ready
    );

    modport sink (
        input  valid, rec_kind, out_id_a, out_id_b, out_fwd, a_beg, a_fin,
               b_beg, b_fin, hang_a, hang_b, err_rate,
        output ready
    );
endinterface

@@ hw/rtl/overlap_dedup_record_convert.sv @@
// ----------------------------------------------------------------------------
// overlap_dedup_record_convert: deduplicating alignment record converter
// Keeps one cached record, replaces it with better records of the same pair,
// and emits it as a trim or hang record when a new pair or a flush arrives.
// ----------------------------------------------------------------------------
// An emitting item passes through decide, multiply, saturation check, 16
// restoring divider steps and output load; the load waits for the output
// register to be free. The input stays closed until an item is finished, so
// items are taken one at a time, and only emitting items use the divider.
// Reset (rst_n, asynchronous, active low) empties the cache and the output
// register and sets the mode to trim records.
module overlap_dedup_record_convert
    import odrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    odrc_in_if.sink    rec_in,
    odrc_out_if.source rec_out
);

    cmd_t    cmd;
    status_t st;

    odrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    odrc_dp #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rec_in    (rec_in),
        .rec_out   (rec_out),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

@@ hw/rtl/odrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// odrc_ctrl: sequencing controller
// Steps each item through decide and, when it emits, multiply, check, divide and output write.
// ----------------------------------------------------------------------------
module odrc_ctrl
    import odrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_MULT   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_WRITE  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (st.in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (st.is_flush)
                begin
                    if (st.cache_valid)
                    begin
                        cmd.load_work = 1'b1;
                        cmd.clear     = 1'b1;
                        state_next    = S_MULT;
                    end
                end
                else if (st.keep)
                begin
                    if (!st.cache_valid)
                    begin
                        cmd.store = 1'b1;
                    end
                    else if (st.same_key)
                    begin
                        cmd.store = st.better;
                    end
                    else
                    begin
                        // emit the cached record and replace it with the new one
                        cmd.load_work = 1'b1;
                        cmd.store     = 1'b1;
                        state_next    = S_MULT;
                    end
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(ERATE_BITS - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (st.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/odrc_dp.sv @@
// ----------------------------------------------------------------------------
// odrc_dp: record datapath
// Input capture, record cache, comparison logic, error-rate divider and the
// output register with its conversion to trim or hang form.
// ----------------------------------------------------------------------------
module odrc_dp
    import odrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    odrc_in_if.sink        rec_in,
    odrc_out_if.source     rec_out,
    input  cmd_t           cmd,
    output status_t        st
);

    localparam int PW = NUM_BITS + COORD_BITS;
    localparam int HW = COORD_BITS + HANG_BITS;

    typedef logic [N_CRD-1:0][COORD_BITS-1:0] crd_t;

    // configuration
    logic mode_reg;

    // captured item
    logic                 in_func_reg;
    logic [ID_BITS-1:0]   in_ida_reg, in_idb_reg;
    logic                 in_fwd_reg;
    crd_t                 in_crd_reg;
    logic [DIFF_BITS-1:0] in_diffs_reg;

    // cache
    logic                 cache_valid_reg;
    logic [ID_BITS-1:0]   cache_ida_reg, cache_idb_reg;
    logic                 cache_fwd_reg;
    crd_t                 cache_crd_reg;
    logic [DIFF_BITS-1:0] cache_diffs_reg;

    // record under conversion
    logic                 wk_mode_reg;
    logic [ID_BITS-1:0]   wk_ida_reg, wk_idb_reg;
    logic                 wk_fwd_reg;
    crd_t                 wk_crd_reg;
    logic [DIFF_BITS-1:0] wk_diffs_reg;

    // error-rate divider
    logic [NUM_BITS-1:0]   prod_reg;
    logic [COORD_BITS-1:0] span_reg;
    logic                  sat_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [ERATE_BITS-1:0] quo_reg;

    logic out_valid_reg;

    logic                  capture;
    logic [COORD_BITS:0]   rem_sh, rem_sub;
    logic                  rem_ge;
    logic [PW-1:0]         prod_ext, sat_lim;
    logic                  full_left, full_right;
    logic                  reach_n, reach_c;
    logic [COORD_BITS-1:0] span_an, span_bn, span_ac, span_bc;
    logic [HW-1:0]         ha_w, hb_w;

    function automatic logic reaches_end(input crd_t c);
        reaches_end = (c[C_SA] == '0) || (c[C_SB] == '0) ||
                      (c[C_EA] == c[C_LA]) || (c[C_EB] == c[C_LB]);
    endfunction

    function automatic logic [HW-1:0] hext(input logic [COORD_BITS-1:0] v);
        hext = HW'(v);
    endfunction

    // ---------------- status toward the controller ----------------
    assign capture = cmd.take && rec_in.valid;
    assign rec_in.ready = cmd.take;

    assign reach_n = reaches_end(in_crd_reg);
    assign reach_c = reaches_end(cache_crd_reg);
    assign span_an = in_crd_reg[C_EA] - in_crd_reg[C_SA];
    assign span_bn = in_crd_reg[C_EB] - in_crd_reg[C_SB];
    assign span_ac = cache_crd_reg[C_EA] - cache_crd_reg[C_SA];
    assign span_bc = cache_crd_reg[C_EB] - cache_crd_reg[C_SB];

    assign full_left  = (in_crd_reg[C_SA] == '0) ||
                        (in_fwd_reg && in_crd_reg[C_SB] == '0) ||
                        (!in_fwd_reg && in_crd_reg[C_EB] == in_crd_reg[C_LB]);
    assign full_right = (in_crd_reg[C_EA] == in_crd_reg[C_LA]) ||
                        (in_fwd_reg && in_crd_reg[C_EB] == in_crd_reg[C_LB]) ||
                        (!in_fwd_reg && in_crd_reg[C_SB] == '0);

    always_comb
    begin
        st             = '0;
        st.in_valid    = rec_in.valid;
        st.is_flush    = (in_func_reg == FUNC_FLUSH);
        st.keep        = (mode_reg != MODE_HANG) || (full_left && full_right);
        st.cache_valid = cache_valid_reg;
        st.same_key    = (in_ida_reg == cache_ida_reg) &&
                         (in_idb_reg == cache_idb_reg) &&
                         (in_fwd_reg == cache_fwd_reg);
        st.better      = (reach_n && !reach_c) || (span_an > span_ac) ||
                         (span_bn > span_bc);
        st.out_free    = !out_valid_reg || rec_out.ready;
    end

    // ---------------- divider arithmetic ----------------
    assign prod_ext = PW'(prod_reg);
    assign sat_lim  = PW'({span_reg, {ERATE_BITS{1'b0}}});
    assign rem_sh   = {rem_reg, quo_reg[ERATE_BITS-1]};
    assign rem_ge   = rem_sh >= {1'b0, span_reg};
    assign rem_sub  = rem_sh - {1'b0, span_reg};

    // ---------------- hang values, wrapped ----------------
    always_comb
    begin
        if (wk_crd_reg[C_SA] != '0)
        begin
            ha_w = hext(wk_crd_reg[C_SA]);
        end
        else if (wk_fwd_reg)
        begin
            ha_w = '0 - hext(wk_crd_reg[C_SB]);
        end
        else
        begin
            ha_w = hext(wk_crd_reg[C_EB]) - hext(wk_crd_reg[C_LB]);
        end

        if (wk_crd_reg[C_EA] < wk_crd_reg[C_LA])
        begin
            hb_w = hext(wk_crd_reg[C_EA]) - hext(wk_crd_reg[C_LA]);
        end
        else if (wk_fwd_reg)
        begin
            hb_w = hext(wk_crd_reg[C_LB]) - hext(wk_crd_reg[C_EB]);
        end
        else
        begin
            hb_w = hext(wk_crd_reg[C_SB]);
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_TRIM;
            cache_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.store)
            begin
                cache_valid_reg <= 1'b1;
            end
            else if (cmd.clear)
            begin
                cache_valid_reg <= 1'b0;
            end
            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rec_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            in_func_reg        <= rec_in.func;
            in_ida_reg         <= rec_in.id_a;
            in_idb_reg         <= rec_in.id_b;
            in_fwd_reg         <= rec_in.fwd;
            in_crd_reg[C_SA]   <= rec_in.start_a;
            in_crd_reg[C_EA]   <= rec_in.end_a;
            in_crd_reg[C_LA]   <= rec_in.len_a;
            in_crd_reg[C_SB]   <= rec_in.start_b;
            in_crd_reg[C_EB]   <= rec_in.end_b;
            in_crd_reg[C_LB]   <= rec_in.len_b;
            in_diffs_reg       <= rec_in.diffs;
        end

        // the outgoing record leaves the cache before it is overwritten
        if (cmd.load_work)
        begin
            wk_mode_reg  <= mode_reg;
            wk_ida_reg   <= cache_ida_reg;
            wk_idb_reg   <= cache_idb_reg;
            wk_fwd_reg   <= cache_fwd_reg;
            wk_crd_reg   <= cache_crd_reg;
            wk_diffs_reg <= cache_diffs_reg;
        end

        if (cmd.store)
        begin
            cache_ida_reg   <= in_ida_reg;
            cache_idb_reg   <= in_idb_reg;
            cache_fwd_reg   <= in_fwd_reg;
            cache_crd_reg   <= in_crd_reg;
            cache_diffs_reg <= in_diffs_reg;
        end

        if (cmd.mult)
        begin
            prod_reg <= NUM_BITS'(wk_diffs_reg) * NUM_BITS'(ERATE_SCALE);
            span_reg <= wk_crd_reg[C_EA] - wk_crd_reg[C_SA];
        end

        // quotient >= 2^16 (or zero span) saturates; otherwise the top
        // dividend bits are already below the divisor
        if (cmd.check)
        begin
            sat_reg <= prod_ext >= sat_lim;
            rem_reg <= prod_ext[ERATE_BITS +: COORD_BITS];
            quo_reg <= prod_reg[ERATE_BITS-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_ge ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
            quo_reg <= {quo_reg[ERATE_BITS-2:0], rem_ge};
        end

        if (cmd.write)
        begin
            rec_out.rec_kind <= wk_mode_reg;
            rec_out.out_id_a <= wk_ida_reg;
            rec_out.out_id_b <= wk_idb_reg;
            rec_out.out_fwd  <= wk_fwd_reg;
            rec_out.err_rate <= sat_reg ? ERATE_MAX : quo_reg;
            if (wk_mode_reg == MODE_TRIM)
            begin
                rec_out.a_beg  <= wk_crd_reg[C_SA];
                rec_out.a_fin  <= wk_crd_reg[C_EA];
                rec_out.b_beg  <= wk_fwd_reg ? wk_crd_reg[C_SB] : wk_crd_reg[C_EB];
                rec_out.b_fin  <= wk_fwd_reg ? wk_crd_reg[C_EB] : wk_crd_reg[C_SB];
                rec_out.hang_a <= '0;
                rec_out.hang_b <= '0;
            end
            else
            begin
                rec_out.a_beg  <= '0;
                rec_out.a_fin  <= '0;
                rec_out.b_beg  <= '0;
                rec_out.b_fin  <= '0;
                rec_out.hang_a <= ha_w[HANG_BITS-1:0];
                rec_out.hang_b <= hb_w[HANG_BITS-1:0];
            end
        end
    end

    assign rec_out.valid = out_valid_reg;

endmodule

@@ hw/rtl/odrc_checker.sv @@
// ----------------------------------------------------------------------------
// odrc_checker: port-level assertions for the record converter
// Watches the channels of the top level and the record form of each result.
// ----------------------------------------------------------------------------
module odrc_checker
    import odrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  rec_kind,
    input logic [COORD_BITS-1:0] a_beg,
    input logic [COORD_BITS-1:0] a_fin,
    input logic [COORD_BITS-1:0] b_beg,
    input logic [COORD_BITS-1:0] b_fin,
    input logic [HANG_BITS-1:0]  hang_a,
    input logic [HANG_BITS-1:0]  hang_b,
    input logic [ERATE_BITS-1:0] err_rate
);

    // a held result keeps its error rate, kind, a_beg and hang_a
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(err_rate) &&
        $stable(rec_kind) && $stable(a_beg) && $stable(hang_a))
        else $error("result changed while stalled");

    // one item at a time: input closes right after an item is taken
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input stayed open after accepting an item");

    a_trim_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_kind == MODE_TRIM |-> hang_a == '0 && hang_b == '0)
        else $error("trim record carries hang values");

    a_hang_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_kind == MODE_HANG |->
        a_beg == '0 && a_fin == '0 && b_beg == '0 && b_fin == '0)
        else $error("hang record carries trim coordinates");

endmodule

bind overlap_dedup_record_convert odrc_checker #(
    .COORD_BITS (COORD_BITS)
) u_odrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rec_in.valid),
    .in_ready  (rec_in.ready),
    .out_valid (rec_out.valid),
    .out_ready (rec_out.ready),
    .rec_kind  (rec_out.rec_kind),
    .a_beg     (rec_out.a_beg),
    .a_fin     (rec_out.a_fin),
    .b_beg     (rec_out.b_beg),
    .b_fin     (rec_out.b_fin),
    .hang_a    (rec_out.hang_a),
    .hang_b    (rec_out.hang_b),
    .err_rate  (rec_out.err_rate)
);
